### hdl/twcr_pkg.sv
// Shared types, constants and codes for the textured wall column renderer.
`timescale 1ns / 1ps

package twcr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_BITS      = 12;
    localparam int CFG_DIM_W     = 13;
    localparam int COLOR_W       = 24;
    localparam int LH_W          = 16;
    localparam int COORD_W       = 31;
    localparam int DIR_W         = 32;
    localparam int STEP_W        = 32;
    localparam int POS_W         = 40;
    localparam int BASE_W        = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int TEX_IDX_W     = 2;
    localparam int CLASS_W       = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR   = 3'd4;

    localparam logic [CFG_DIM_W-1:0] TEX_WIDTH_RST     = 13'd64;
    localparam logic [CFG_DIM_W-1:0] TEX_HEIGHT_RST    = 13'd64;
    localparam logic [CFG_DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Input item kinds.
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    // Pixel classes.
    localparam logic [CLASS_W-1:0] PC_CEILING = 2'd0;
    localparam logic [CLASS_W-1:0] PC_TEXEL   = 2'd1;
    localparam logic [CLASS_W-1:0] PC_FLOOR   = 2'd2;
    localparam logic [CLASS_W-1:0] PC_NONE    = 2'd3;

    // Wall texture selection by hit side and step sign.
    localparam logic [TEX_IDX_W-1:0] TEX_X_NEG = 2'd0;
    localparam logic [TEX_IDX_W-1:0] TEX_Y_NEG = 2'd1;
    localparam logic [TEX_IDX_W-1:0] TEX_Y_POS = 2'd2;
    localparam logic [TEX_IDX_W-1:0] TEX_X_POS = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_SETUP
    } t_top_state;

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_HIT,
        SU_FRAC,
        SU_TEX,
        SU_TXOUT,
        SU_DIV,
        SU_POS,
        SU_DONE
    } t_su_state;

    typedef struct packed {
        logic                 hit_side;
        logic                 step_positive;
        logic [COORD_W-1:0]   coord;
        logic [DIR_W-1:0]     dir;
        logic [COORD_W-1:0]   distance;
        logic [LH_W-1:0]      line_height;
        logic [DIM_BITS-1:0]  slice_top;
        logic [CFG_DIM_W-1:0] screen_height;
        logic [CFG_DIM_W-1:0] tex_width;
        logic [CFG_DIM_W-1:0] tex_height;
    } t_setup_req;

    typedef struct packed {
        logic [DIM_BITS-1:0]  texel_x;
        logic [TEX_IDX_W-1:0] texture;
        logic [STEP_W-1:0]    step;
        logic [POS_W-1:0]     position;
    } t_setup_res;

endpackage

### hdl/textured_wall_column_renderer.sv
// Top level of the textured wall column renderer: stream ports, config registers, row stepping.
`timescale 1ns / 1ps

// A column item (tuser = 0) sets up texture mapping for one wall slice and produces no
// transfer on the output; it holds the input stream while one shared adder runs the setup
// serially: a bit-serial multiply for the wall hit, another for the texel column, a
// restoring divide for the vertical step and a final multiply for the starting texture
// position. A row item gives one pixel transfer; the output register takes the next row
// in the same cycle as the waiting pixel is taken, so rows stream at one per cycle while
// the receiver keeps up and the input stalls while it holds off. Row items sent while no
// column is active are consumed and give nothing.

module textured_wall_column_renderer #(
    parameter int FRAC_BITS = twcr_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // hit_side, step_positive, player_x, player_y, ray_dir_x, ray_dir_y, wall_distance,
    // line_height, slice_top, slice_bottom, column, zero padding
    input  logic [215:0] i_s_axis_tdata,
    // kind
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_column, out_row, texture_index, texel_x, texel_y, color, zero padding
    output logic [79:0]  o_m_axis_tdata,
    // pixel_class
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    localparam int DB = twcr_pkg::DIM_BITS;
    localparam int CW = twcr_pkg::CFG_DIM_W;
    localparam logic [CW-1:0] ROW_MAX = CW'(1 << DB);

    twcr_pkg::t_top_state r_state, n_state;

    logic [CW-1:0]                  r_tex_width;
    logic [CW-1:0]                  r_tex_height;
    logic [CW-1:0]                  r_screen_height;
    logic [twcr_pkg::COLOR_W-1:0]   r_ceiling_color;
    logic [twcr_pkg::COLOR_W-1:0]   r_floor_color;

    logic                           r_col_active, n_col_active;
    logic [DB-1:0]                  r_row, n_row;
    logic [DB-1:0]                  r_cur_column, n_cur_column;
    logic [DB-1:0]                  r_cur_top, n_cur_top;
    logic [DB-1:0]                  r_cur_bottom, n_cur_bottom;
    logic [DB-1:0]                  r_cur_texel_x, n_cur_texel_x;
    logic [twcr_pkg::TEX_IDX_W-1:0] r_cur_texture, n_cur_texture;
    logic [twcr_pkg::STEP_W-1:0]    r_tex_step, n_tex_step;
    logic [twcr_pkg::POS_W-1:0]     r_tex_pos, n_tex_pos;

    logic                           r_out_valid, n_out_valid;
    logic [DB-1:0]                  r_out_column, n_out_column;
    logic [DB-1:0]                  r_out_row, n_out_row;
    logic [twcr_pkg::CLASS_W-1:0]   r_out_class, n_out_class;
    logic [twcr_pkg::TEX_IDX_W-1:0] r_out_texture, n_out_texture;
    logic [DB-1:0]                  r_out_texel_x, n_out_texel_x;
    logic [DB-1:0]                  r_out_texel_y, n_out_texel_y;
    logic [twcr_pkg::COLOR_W-1:0]   r_out_color, n_out_color;
    logic                           r_out_last, n_out_last;

    // Input fields.
    logic                           w_hit_side;
    logic                           w_step_positive;
    logic [twcr_pkg::COORD_W-1:0]   w_player_x;
    logic [twcr_pkg::COORD_W-1:0]   w_player_y;
    logic [twcr_pkg::DIR_W-1:0]     w_ray_dir_x;
    logic [twcr_pkg::DIR_W-1:0]     w_ray_dir_y;
    logic [twcr_pkg::COORD_W-1:0]   w_wall_distance;
    logic [twcr_pkg::LH_W-1:0]      w_line_height;
    logic [DB-1:0]                  w_slice_top;
    logic [DB-1:0]                  w_slice_bottom;
    logic [DB-1:0]                  w_column;

    assign w_hit_side      = i_s_axis_tdata[0];
    assign w_step_positive = i_s_axis_tdata[1];
    assign w_player_x      = i_s_axis_tdata[32:2];
    assign w_player_y      = i_s_axis_tdata[63:33];
    assign w_ray_dir_x     = i_s_axis_tdata[95:64];
    assign w_ray_dir_y     = i_s_axis_tdata[127:96];
    assign w_wall_distance = i_s_axis_tdata[158:128];
    assign w_line_height   = i_s_axis_tdata[174:159];
    assign w_slice_top     = i_s_axis_tdata[186:175];
    assign w_slice_bottom  = i_s_axis_tdata[198:187];
    assign w_column        = i_s_axis_tdata[210:199];

    logic                 w_s_acc;
    logic                 w_is_col;
    logic                 w_su_done;
    twcr_pkg::t_setup_req w_req;
    twcr_pkg::t_setup_res w_res;
    logic [CW-1:0]        w_row_limit;
    logic [CW-1:0]        w_row_next;
    logic [CW-1:0]        w_hmask;
    logic                 w_last;

    assign o_s_axis_tready = (r_state == twcr_pkg::ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_col        = (i_s_axis_tuser[0] == twcr_pkg::KIND_COLUMN);

    assign w_row_limit = (r_screen_height > ROW_MAX) ? ROW_MAX : r_screen_height;
    assign w_row_next  = {1'b0, r_row} + CW'(1);
    assign w_last      = (w_row_next >= w_row_limit);
    assign w_hmask     = r_tex_height - CW'(1);

    always_comb begin
        w_req.hit_side      = w_hit_side;
        w_req.step_positive = w_step_positive;
        w_req.coord         = w_hit_side ? w_player_x : w_player_y;
        w_req.dir           = w_hit_side ? w_ray_dir_x : w_ray_dir_y;
        w_req.distance      = w_wall_distance;
        w_req.line_height   = w_line_height;
        w_req.slice_top     = w_slice_top;
        w_req.screen_height = r_screen_height;
        w_req.tex_width     = r_tex_width;
        w_req.tex_height    = r_tex_height;
    end

    twcr_setup_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_s_acc && w_is_col),
        .i_req   (w_req),
        .o_done  (w_su_done),
        .o_res   (w_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            twcr_pkg::ST_IDLE:  if (w_s_acc && w_is_col) n_state = twcr_pkg::ST_SETUP;
            twcr_pkg::ST_SETUP: if (w_su_done) n_state = twcr_pkg::ST_IDLE;
            default:            n_state = twcr_pkg::ST_IDLE;
        endcase
    end

    // Column state, row stepping and the output register.
    always_comb begin
        n_col_active  = r_col_active;
        n_row         = r_row;
        n_cur_column  = r_cur_column;
        n_cur_top     = r_cur_top;
        n_cur_bottom  = r_cur_bottom;
        n_cur_texel_x = r_cur_texel_x;
        n_cur_texture = r_cur_texture;
        n_tex_step    = r_tex_step;
        n_tex_pos     = r_tex_pos;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_column  = r_out_column;
        n_out_row     = r_out_row;
        n_out_class   = r_out_class;
        n_out_texture = r_out_texture;
        n_out_texel_x = r_out_texel_x;
        n_out_texel_y = r_out_texel_y;
        n_out_color   = r_out_color;
        n_out_last    = r_out_last;

        if (w_su_done) begin
            n_cur_texel_x = w_res.texel_x;
            n_cur_texture = w_res.texture;
            n_tex_step    = w_res.step;
            n_tex_pos     = w_res.position;
        end

        if (w_s_acc && w_is_col) begin
            n_cur_top    = w_slice_top;
            n_cur_bottom = w_slice_bottom;
            n_cur_column = w_column;
            n_row        = '0;
            n_col_active = (r_screen_height != '0);
        end else if (w_s_acc && r_col_active) begin
            n_out_valid   = 1'b1;
            n_out_column  = r_cur_column;
            n_out_row     = r_row;
            n_out_class   = twcr_pkg::PC_NONE;
            n_out_texture = '0;
            n_out_texel_x = '0;
            n_out_texel_y = '0;
            n_out_color   = '0;
            n_out_last    = w_last;
            // Tests go in this order; rows equal to the top or bottom stay untouched.
            if (r_row < r_cur_top) begin
                n_out_class = twcr_pkg::PC_CEILING;
                n_out_color = r_ceiling_color;
            end else if (r_row > r_cur_top && r_row < r_cur_bottom) begin
                n_out_class   = twcr_pkg::PC_TEXEL;
                n_out_texture = r_cur_texture;
                n_out_texel_x = r_cur_texel_x;
                n_out_texel_y = r_tex_pos[FRAC_BITS +: DB] & w_hmask[DB-1:0];
                n_tex_pos     = r_tex_pos + twcr_pkg::POS_W'(r_tex_step);
            end else if (r_row > r_cur_bottom) begin
                n_out_class = twcr_pkg::PC_FLOOR;
                n_out_color = r_floor_color;
            end
            n_row = w_row_next[DB-1:0];
            if (w_last) begin
                n_col_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= twcr_pkg::ST_IDLE;
            r_col_active    <= 1'b0;
            r_row           <= '0;
            r_out_valid     <= 1'b0;
            r_tex_width     <= twcr_pkg::TEX_WIDTH_RST;
            r_tex_height    <= twcr_pkg::TEX_HEIGHT_RST;
            r_screen_height <= twcr_pkg::SCREEN_HEIGHT_RST;
            r_ceiling_color <= '0;
            r_floor_color   <= '0;
        end else begin
            r_state      <= n_state;
            r_col_active <= n_col_active;
            r_row        <= n_row;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    twcr_pkg::CFG_TEX_WIDTH:     r_tex_width     <= i_cfg_data[CW-1:0];
                    twcr_pkg::CFG_TEX_HEIGHT:    r_tex_height    <= i_cfg_data[CW-1:0];
                    twcr_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[CW-1:0];
                    twcr_pkg::CFG_CEILING_COLOR: r_ceiling_color <= i_cfg_data;
                    twcr_pkg::CFG_FLOOR_COLOR:   r_floor_color   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_column  <= n_cur_column;
        r_cur_top     <= n_cur_top;
        r_cur_bottom  <= n_cur_bottom;
        r_cur_texel_x <= n_cur_texel_x;
        r_cur_texture <= n_cur_texture;
        r_tex_step    <= n_tex_step;
        r_tex_pos     <= n_tex_pos;
        r_out_column  <= n_out_column;
        r_out_row     <= n_out_row;
        r_out_class   <= n_out_class;
        r_out_texture <= n_out_texture;
        r_out_texel_x <= n_out_texel_x;
        r_out_texel_y <= n_out_texel_y;
        r_out_color   <= n_out_color;
        r_out_last    <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_color, r_out_texel_y, r_out_texel_x,
                              r_out_texture, r_out_row, r_out_column};
    assign o_m_axis_tuser  = r_out_class;
    assign o_m_axis_tlast  = r_out_last;

    a_done_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_su_done |-> (r_state == twcr_pkg::ST_SETUP))
        else $error("setup finished outside of a column setup");

    a_col_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_is_col) |=> (r_state == twcr_pkg::ST_SETUP && r_row == '0))
        else $error("column item did not start setup at row zero");

    a_texel_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_class == twcr_pkg::PC_TEXEL)
            |-> (r_out_row > r_cur_top && r_out_row < r_cur_bottom))
        else $error("texel pixel outside the wall slice");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !w_is_col && r_col_active && w_last) |=> !r_col_active)
        else $error("last row did not end the column");

endmodule

### hdl/twcr_setup_unit.sv
// Column setup sequencer built around one shared adder: texel column, step and start position.
`timescale 1ns / 1ps

module twcr_setup_unit #(
    parameter int FRAC_BITS = twcr_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  twcr_pkg::t_setup_req i_req,
    output logic                 o_done,
    output twcr_pkg::t_setup_res o_res
);

    localparam int ACC_W  = (2 * FRAC_BITS > twcr_pkg::POS_W) ? 2 * FRAC_BITS
                                                               : twcr_pkg::POS_W;
    localparam int DIVD_W = twcr_pkg::CFG_DIM_W + FRAC_BITS;
    localparam int QW     = (DIVD_W > twcr_pkg::STEP_W) ? DIVD_W : twcr_pkg::STEP_W + 1;
    localparam int PART_W = twcr_pkg::LH_W + 1;
    localparam int CNT_W  = 6;
    localparam logic [CNT_W-1:0] HIT_LAST = CNT_W'(twcr_pkg::COORD_W - 1);
    localparam logic [CNT_W-1:0] TEX_LAST = CNT_W'(twcr_pkg::CFG_DIM_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIVD_W - 1);
    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(twcr_pkg::STEP_W - 1);

    twcr_pkg::t_su_state r_state, n_state;

    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [ACC_W-1:0]                 r_acc, n_acc;
    logic [ACC_W-1:0]                 r_mcand, n_mcand;
    logic [twcr_pkg::STEP_W-1:0]      r_mplier, n_mplier;
    logic [DIVD_W-1:0]                r_quo, n_quo;
    logic [twcr_pkg::LH_W-1:0]        r_div, n_div;
    logic [twcr_pkg::COORD_W-1:0]     r_coord, n_coord;
    logic [twcr_pkg::CFG_DIM_W-1:0]   r_tw, n_tw;
    logic [twcr_pkg::CFG_DIM_W-1:0]   r_th, n_th;
    logic signed [twcr_pkg::BASE_W-1:0] r_base, n_base;
    logic [twcr_pkg::DIM_BITS-1:0]    r_texel_x, n_texel_x;
    logic [twcr_pkg::TEX_IDX_W-1:0]   r_texture, n_texture;
    logic [twcr_pkg::STEP_W-1:0]      r_step, n_step;

    // Shared adder and its operand selection.
    logic [ACC_W-1:0]  w_add_a;
    logic [ACC_W-1:0]  w_add_b;
    logic              w_add_cin;
    logic [ACC_W:0]    w_sum;
    logic [PART_W-1:0] w_partial;
    logic [DIVD_W-1:0] w_quo_next;
    logic [QW-1:0]     w_quo_ext;
    logic [twcr_pkg::STEP_W-1:0] w_step_sat;
    logic [CNT_W-1:0]  w_cnt_last;
    logic              w_last;

    assign w_partial  = {r_acc[twcr_pkg::LH_W-1:0], r_quo[DIVD_W-1]};
    assign w_sum      = {1'b0, w_add_a} + {1'b0, w_add_b} + (ACC_W + 1)'(w_add_cin);
    assign w_quo_next = {r_quo[DIVD_W-2:0], w_sum[ACC_W]};
    assign w_quo_ext  = QW'(w_quo_next);
    assign w_step_sat = (|w_quo_ext[QW-1:twcr_pkg::STEP_W]) ? '1
                                                             : w_quo_ext[twcr_pkg::STEP_W-1:0];
    assign w_last     = (r_cnt == w_cnt_last);

    always_comb begin
        w_add_a    = r_acc;
        w_add_b    = '0;
        w_add_cin  = 1'b0;
        w_cnt_last = HIT_LAST;
        case (r_state)
            twcr_pkg::SU_HIT: begin
                w_add_b = r_mcand;
            end
            twcr_pkg::SU_FRAC: begin
                w_add_a = ACC_W'(r_coord);
                w_add_b = r_acc >> FRAC_BITS;
            end
            twcr_pkg::SU_TEX: begin
                w_add_b    = r_mcand;
                w_cnt_last = TEX_LAST;
            end
            twcr_pkg::SU_TXOUT: begin
                // Width plus the complement of the texel column gives width - column - 1.
                w_add_a = ACC_W'(r_tw);
                w_add_b = ~(r_acc >> FRAC_BITS);
            end
            twcr_pkg::SU_DIV: begin
                w_add_a    = ACC_W'(w_partial);
                w_add_b    = ~ACC_W'(r_div);
                w_add_cin  = 1'b1;
                w_cnt_last = DIV_LAST;
            end
            twcr_pkg::SU_POS: begin
                w_add_b    = r_mcand;
                w_cnt_last = POS_LAST;
            end
            default: begin
                w_add_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            twcr_pkg::SU_IDLE:  if (i_start) n_state = twcr_pkg::SU_HIT;
            twcr_pkg::SU_HIT:   if (w_last) n_state = twcr_pkg::SU_FRAC;
            twcr_pkg::SU_FRAC:  n_state = twcr_pkg::SU_TEX;
            twcr_pkg::SU_TEX:   if (w_last) n_state = twcr_pkg::SU_TXOUT;
            twcr_pkg::SU_TXOUT: n_state = twcr_pkg::SU_DIV;
            twcr_pkg::SU_DIV:   if (w_last) n_state = twcr_pkg::SU_POS;
            twcr_pkg::SU_POS:   if (w_last) n_state = twcr_pkg::SU_DONE;
            twcr_pkg::SU_DONE:  n_state = twcr_pkg::SU_IDLE;
            default:            n_state = twcr_pkg::SU_IDLE;
        endcase
    end

    // Datapath.
    always_comb begin
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_quo     = r_quo;
        n_div     = r_div;
        n_coord   = r_coord;
        n_tw      = r_tw;
        n_th      = r_th;
        n_base    = r_base;
        n_texel_x = r_texel_x;
        n_texture = r_texture;
        n_step    = r_step;
        case (r_state)
            twcr_pkg::SU_IDLE: begin
                if (i_start) begin
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_mcand  = ACC_W'($signed(i_req.dir));
                    n_mplier = twcr_pkg::STEP_W'(i_req.distance);
                    n_coord  = i_req.coord;
                    n_tw     = i_req.tex_width;
                    n_th     = i_req.tex_height;
                    n_div    = (i_req.line_height == '0) ? twcr_pkg::LH_W'(1)
                                                         : i_req.line_height;
                    n_base   = $signed(
                        {{(twcr_pkg::BASE_W - twcr_pkg::DIM_BITS){1'b0}}, i_req.slice_top}
                      + {{(twcr_pkg::BASE_W - twcr_pkg::LH_W + 1){1'b0}},
                         i_req.line_height[twcr_pkg::LH_W-1:1]}
                      - {{(twcr_pkg::BASE_W - twcr_pkg::CFG_DIM_W + 1){1'b0}},
                         i_req.screen_height[twcr_pkg::CFG_DIM_W-1:1]});
                    if (i_req.hit_side == 1'b0) begin
                        n_texture = i_req.step_positive ? twcr_pkg::TEX_X_POS
                                                        : twcr_pkg::TEX_X_NEG;
                    end else begin
                        n_texture = i_req.step_positive ? twcr_pkg::TEX_Y_POS
                                                        : twcr_pkg::TEX_Y_NEG;
                    end
                end
            end
            twcr_pkg::SU_HIT, twcr_pkg::SU_TEX, twcr_pkg::SU_POS: begin
                if (r_mplier[0]) begin
                    n_acc = w_sum[ACC_W-1:0];
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = w_last ? '0 : r_cnt + 1'b1;
            end
            twcr_pkg::SU_FRAC: begin
                // Only the fraction of the wall hit matters from here on.
                n_mcand  = ACC_W'(w_sum[FRAC_BITS-1:0]);
                n_mplier = twcr_pkg::STEP_W'(r_tw);
                n_acc    = '0;
            end
            twcr_pkg::SU_TXOUT: begin
                n_texel_x = w_sum[twcr_pkg::DIM_BITS-1:0];
                n_acc     = '0;
                n_quo     = {r_th, {FRAC_BITS{1'b0}}};
            end
            twcr_pkg::SU_DIV: begin
                // Restoring division, one quotient bit per cycle; the carry means no borrow.
                n_acc = w_sum[ACC_W] ? ACC_W'(w_sum[twcr_pkg::LH_W-1:0])
                                     : ACC_W'(w_partial[twcr_pkg::LH_W-1:0]);
                n_quo = w_quo_next;
                n_cnt = w_last ? '0 : r_cnt + 1'b1;
                if (w_last) begin
                    n_step   = w_step_sat;
                    n_acc    = '0;
                    n_mcand  = ACC_W'(r_base);
                    n_mplier = w_step_sat;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twcr_pkg::SU_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_mcand   <= n_mcand;
        r_mplier  <= n_mplier;
        r_quo     <= n_quo;
        r_div     <= n_div;
        r_coord   <= n_coord;
        r_tw      <= n_tw;
        r_th      <= n_th;
        r_base    <= n_base;
        r_texel_x <= n_texel_x;
        r_texture <= n_texture;
        r_step    <= n_step;
    end

    assign o_done         = (r_state == twcr_pkg::SU_DONE);
    assign o_res.texel_x  = r_texel_x;
    assign o_res.texture  = r_texture;
    assign o_res.step     = r_step;
    assign o_res.position = r_acc[twcr_pkg::POS_W-1:0];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == twcr_pkg::SU_IDLE))
        else $error("setup started while the unit was busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("setup done held for more than one cycle");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twcr_pkg::SU_DIV) |-> (r_acc < ACC_W'(r_div)))
        else $error("division remainder not below divisor");

endmodule
